// File: sv/lps_pkg.sv
// Package for the lexicographic point sorter.
// Holds payload types, sizing constants and the controller/datapath interface.
// No dependencies.
package lps_pkg;

  localparam int MaxPoints = 32;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int OutIdxW   = 5;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               is_last;
  } lps_point_t;

  typedef struct packed {
    logic [OutIdxW-1:0] sorted_index;
    logic signed [15:0] sorted_x;
    logic signed [15:0] sorted_y;
    logic               overflowed;
    logic               last_result;
  } lps_result_t;

  // one slot of the sorted insertion chain
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [IdxW-1:0]    idx;
  } lps_slot_t;

  typedef struct packed {
    logic ins;       // insert incoming point into the chain
    logic set_drop;  // chain full, point discarded
    logic shift;     // pop head slot toward the output
    logic clear;     // end of set
  } lps_cmd_t;

  typedef struct packed {
    logic full;
    logic last_one;  // exactly one point left in the chain
  } lps_status_t;

endpackage

// File: sv/lps_ctrl.sv
// Controller for the lexicographic point sorter: load / emit state machine.
// Depends on lps_pkg.
module lps_ctrl import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_last_i,
  input  lps_status_t status_i,
  output lps_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        result_valid_o
);

  localparam logic StLoad = 1'b0;
  localparam logic StEmit = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == StLoad);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      StLoad: begin
        cmd_o.ins      = accept && !status_i.full;
        cmd_o.set_drop = accept && status_i.full;
        if (accept && is_last_i) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.shift = 1'b1;
        if (status_i.last_one) begin
          cmd_o.clear = 1'b1;
          state_d     = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q == StEmit);
  assign result_valid_o = (state_q == StEmit);

  // the final result of a set always hands back to loading
  a_emit_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && status_i.last_one) |=> (state_q == StLoad))
    else $error("emission did not end after last point");

endmodule

// File: sv/lps_datapath.sv
// Datapath for the lexicographic point sorter: a sorted insertion chain of
// slots, point count and drop flag. Depends on lps_pkg.
module lps_datapath import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lps_cmd_t    cmd_i,
  input  lps_point_t  point_i,
  output lps_status_t status_o,
  output lps_result_t result_o
);

  lps_slot_t slot_q [MaxPoints];
  lps_slot_t slot_d [MaxPoints];
  lps_slot_t prev   [MaxPoints];
  lps_slot_t nxt    [MaxPoints];
  logic [MaxPoints-1:0] le;
  logic [MaxPoints-1:0] le_prev;
  logic [CntW-1:0] count_q, count_d;
  logic drop_q, drop_d;
  lps_slot_t new_slot;

  assign new_slot.x   = point_i.point_x;
  assign new_slot.y   = point_i.point_y;
  assign new_slot.idx = count_q[IdxW-1:0];

  // Chain is kept ascending; empty slots count as +infinity. The new point
  // has the highest index so far, so it goes ahead of identical points.
  always_comb begin
    for (int k = 0; k < MaxPoints; k++) begin
      le[k] = (CntW'(k) >= count_q) ||
              (new_slot.x < slot_q[k].x) ||
              ((new_slot.x == slot_q[k].x) && (new_slot.y <= slot_q[k].y));
    end
    prev[0]    = new_slot;
    le_prev[0] = 1'b0;
    nxt[MaxPoints-1] = slot_q[MaxPoints-1];
    for (int k = 1; k < MaxPoints; k++) begin
      prev[k]    = slot_q[k-1];
      le_prev[k] = le[k-1];
      nxt[k-1]   = slot_q[k];
    end
    for (int k = 0; k < MaxPoints; k++) begin
      slot_d[k] = slot_q[k];
      if (cmd_i.ins && le[k]) begin
        slot_d[k] = le_prev[k] ? prev[k] : new_slot;
      end else if (cmd_i.shift) begin
        slot_d[k] = nxt[k];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (cmd_i.ins) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.shift) begin
      count_d = count_q - CntW'(1);
    end
    if (cmd_i.set_drop) begin
      drop_d = 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxPoints; k++) begin
      slot_q[k] <= slot_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  assign status_o.full     = (count_q == CntW'(MaxPoints));
  assign status_o.last_one = (count_q == CntW'(1));

  assign result_o.sorted_index = OutIdxW'(slot_q[0].idx);
  assign result_o.sorted_x     = slot_q[0].x;
  assign result_o.sorted_y     = slot_q[0].y;
  assign result_o.overflowed   = drop_q;
  assign result_o.last_result  = status_o.last_one;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxPoints))
    else $error("point count beyond capacity");

  a_shift_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> (count_q != '0))
    else $error("emitting from an empty chain");

  a_ins_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> !(cmd_i.shift || cmd_i.set_drop))
    else $error("insert overlaps emit or drop");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ins && !cmd_i.clear) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance count");

endmodule

// File: sv/lexicographic_point_sorter.sv
// Top level of the lexicographic point sorter.
// Depends on lps_pkg, lps_ctrl and lps_datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------
//  point in | start_i high, busy_o low | point_i  (lps_point_t)
//  result   | result_valid_o strobe    | result_o (lps_result_t)
//
// Loading takes one point per cycle: each point is placed into a sorted chain
// of MaxPoints slots by parallel compares in the cycle it arrives. After the
// last point, busy_o stays high while the chain shifts out one result per
// cycle from its head, until every stored point has been emitted.
// Reset leaves the chain empty; slot contents are not reset. The receiver
// cannot stall: each result is on the ports for exactly one cycle.
module lexicographic_point_sorter import lps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  lps_point_t  point_i,
  output logic        result_valid_o,
  output lps_result_t result_o
);

  lps_cmd_t    cmd;
  lps_status_t status;

  lps_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .is_last_i      (point_i.is_last),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  lps_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .point_i  (point_i),
    .status_o (status),
    .result_o (result_o)
  );

endmodule
